/* hw/rtl/three_phase_current_controller_top_defines.svh */
// Assertion macros for the checker of the current controller
`ifndef THREE_PHASE_CURRENT_CONTROLLER_TOP_DEFINES_SVH
`define THREE_PHASE_CURRENT_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, idle while reset is low
`define TPCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle while reset is low
`define TPCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tpcc_pkg.sv */
// Shared widths, formats and register codes of the current controller
package tpcc_pkg;

    localparam int SIG_W      = 16;     // Q12.4 signal
    localparam int BUS_W      = 15;     // bus voltage, unsigned Q11.4
    localparam int OUT_W      = 15;     // bridge command
    localparam int RATE_W     = 16;     // filter corner and period registers
    localparam int GAIN_W     = 18;     // Q8.10 gain
    localparam int GAIN_FRAC  = 10;
    localparam int COEF_W     = 25;     // filter coefficient, Q1.24 up to 1.0
    localparam int COEF_FRAC  = 24;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    // shared multiplier: signed A times signed B
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 26;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int CHUNK_W    = MUL_A_W - 1;   // digit of a wide filter difference

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int PHASE_COUNT_DEF = 3;
    localparam int STATE_BITS_DEF  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_RATE       = 3'd0,
        CFG_DAMP_RATE         = 3'd1,
        CFG_DAMP_GAIN         = 3'd2,
        CFG_SLOW_RATE         = 3'd3,
        CFG_FEEDFORWARD_GAIN  = 3'd4,
        CFG_PROPORTIONAL_GAIN = 3'd5,
        CFG_SLOW_GAIN         = 3'd6,
        CFG_SAMPLE_PERIOD     = 3'd7
    } t_cfg_idx;

endpackage

/* hw/rtl/three_phase_current_controller_top.sv */
// Three-phase current controller: offset tracking, virtual damper and bridge command
//
// One request on s_axis carries a control tick: enable, bus voltage, then the AC voltages,
// measured currents and current references of every phase. One result on m_axis carries
// the clamped bridge voltage command of every phase. The user must write configuration
// through i_cfg_we / i_cfg_addr / i_cfg_wdata only while no tick is in flight; the block
// itself does not enforce this. A single 18x26 multiplier does all products: operands
// are applied, then the product is registered. Each filter update folds the D digits of
// the filter difference in from the top, D being 2 for 32-bit filter state. The three
// coefficients come first; then per phase the offset filter (only when disabled), the
// damper filter, the damping gain, the error, the slow filter, the three output terms
// and the clamp, and last the result is loaded; s_axis_tready rises in the cycle after.
// s_axis_tready is high only while the block is idle. A finished result waits in the
// output register; if the receiver stalls and a second result is done, the block holds
// it until the first is taken. Reset clears the sequencer and configuration registers,
// the filter states and the output valid.
module three_phase_current_controller_top import tpcc_pkg::*; #(
    parameter int PHASE_COUNT = PHASE_COUNT_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // enable, bus_voltage, v_ac[phases], i_meas[phases], i_target[phases]
    input  logic [1+BUS_W+3*SIG_W*PHASE_COUNT-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bridge[phases], zero padded to whole bytes
    output logic [((OUT_W*PHASE_COUNT+7)/8)*8-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int IN_W      = 1 + BUS_W + 3*SIG_W*PHASE_COUNT;
    localparam int OBUS_W    = ((OUT_W*PHASE_COUNT+7)/8)*8;
    localparam int VAC_LO    = 1 + BUS_W;
    localparam int IM_LO     = VAC_LO + SIG_W*PHASE_COUNT;
    localparam int IT_LO     = IM_LO + SIG_W*PHASE_COUNT;
    localparam int SIG_SHIFT = STATE_BITS - SIG_W;
    localparam int DIFF_W    = STATE_BITS + 1;
    localparam int NCH       = (DIFF_W + CHUNK_W - 1) / CHUNK_W;
    localparam int DPAD_W    = NCH * CHUNK_W;
    localparam int ACC_W     = DIFF_W + COEF_W;
    localparam int CK_W      = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PH_W      = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    localparam logic [CK_W-1:0] CK_TOP  = CK_W'(NCH - 1);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASE_COUNT - 1);
    localparam logic signed [MUL_P_W-1:0] SIG_MAX = MUL_P_W'((2**(SIG_W-1)) - 1);
    localparam logic signed [MUL_P_W-1:0] SIG_MIN = -MUL_P_W'(2**(SIG_W-1));

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_COEF  = 10'b00_0000_0010,
        S_FSET  = 10'b00_0000_0100,
        S_FMUL  = 10'b00_0000_1000,
        S_FUPD  = 10'b00_0001_0000,
        S_DGAIN = 10'b00_0010_0000,
        S_ERR   = 10'b00_0100_0000,
        S_OUTM  = 10'b00_1000_0000,
        S_CLAMP = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        F_OFF  = 2'd0,
        F_DAMP = 2'd1,
        F_SLOW = 2'd2
    } t_filt;

    typedef enum logic [1:0] {
        T_FF = 2'd0,
        T_KP = 2'd1,
        T_KS = 2'd2
    } t_term;

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [MUL_P_W-1:0] v);
        logic signed [SIG_W-1:0] r;
        if (v > SIG_MAX) begin
            r = SIG_MAX[SIG_W-1:0];
        end else if (v < SIG_MIN) begin
            r = SIG_MIN[SIG_W-1:0];
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [RATE_W-1:0]        r_offset_rate, r_damp_rate, r_slow_rate, r_sample_period;
    logic signed [GAIN_W-1:0] r_damp_gain, r_ff_gain, r_kp_gain, r_ks_gain;

    // filter states, Q12.F
    logic [STATE_BITS-1:0] r_offset [PHASE_COUNT];
    logic [STATE_BITS-1:0] r_damper [PHASE_COUNT];
    logic [STATE_BITS-1:0] r_errlp  [PHASE_COUNT];

    // sequencer
    t_state           r_state, n_state;
    logic             r_wait, n_wait;
    logic [PH_W-1:0]  r_ph, n_ph;
    logic [CK_W-1:0]  r_ck, n_ck;
    t_filt            r_fsel, n_fsel;
    t_term            r_term, n_term;
    logic             r_ovalid, n_ovalid;

    // datapath
    logic [IN_W-1:0]              r_in;
    logic [COEF_W-1:0]            r_coef [3];
    logic [DPAD_W-1:0]            r_diff;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [SIG_W-1:0]      r_ivd, r_err;
    logic [OUT_W*PHASE_COUNT-1:0] r_bridge, r_obus;
    logic signed [MUL_P_W-1:0]    r_prod;

    logic                     c_en, c_load;
    logic [BUS_W-2:0]         c_half;
    logic signed [SIG_W-1:0]  c_vac, c_im, c_it, c_ic, c_hp, c_lp, c_t1, c_err_new;
    logic signed [SIG_W-1:0]  c_fx;
    logic [STATE_BITS-1:0]    c_fs, c_fnew;
    logic [COEF_W-1:0]        c_fcoef, c_coef_sat;
    logic [RATE_W-1:0]        c_rate;
    logic signed [DIFF_W-1:0] c_diff;
    logic [CHUNK_W-1:0]       c_chunk;
    logic signed [MUL_A_W-1:0] c_chunk_op, c_mul_a;
    logic signed [MUL_B_W-1:0] c_mul_b;
    logic signed [ACC_W-1:0]  c_v, c_hi_lim, c_lo_lim, c_clamp;

    assign c_en   = r_in[0];
    assign c_half = r_in[BUS_W:2];
    assign c_vac  = $signed(r_in[VAC_LO + r_ph*SIG_W +: SIG_W]);
    assign c_im   = $signed(r_in[IM_LO  + r_ph*SIG_W +: SIG_W]);
    assign c_it   = $signed(r_in[IT_LO  + r_ph*SIG_W +: SIG_W]);
    assign c_lp   = $signed(r_errlp[r_ph][STATE_BITS-1 -: SIG_W]);

    assign c_ic = sat_sig(MUL_P_W'(c_im)
                  - MUL_P_W'($signed(r_offset[r_ph][STATE_BITS-1 -: SIG_W])));
    assign c_hp = sat_sig(MUL_P_W'(c_vac)
                  - MUL_P_W'($signed(r_damper[r_ph][STATE_BITS-1 -: SIG_W])));
    assign c_t1      = sat_sig(MUL_P_W'(c_it) - MUL_P_W'(r_ivd));
    assign c_err_new = sat_sig(MUL_P_W'(c_t1) - MUL_P_W'(c_ic));

    // filter operand selection
    always_comb begin
        case (r_fsel)
            F_OFF: begin
                c_fx    = c_im;
                c_fs    = r_offset[r_ph];
                c_fcoef = r_coef[F_OFF];
                c_rate  = r_offset_rate;
            end
            F_DAMP: begin
                c_fx    = c_vac;
                c_fs    = r_damper[r_ph];
                c_fcoef = r_coef[F_DAMP];
                c_rate  = r_damp_rate;
            end
            default: begin
                c_fx    = r_err;
                c_fs    = r_errlp[r_ph];
                c_fcoef = r_coef[F_SLOW];
                c_rate  = r_slow_rate;
            end
        endcase
    end

    assign c_diff = DIFF_W'($signed({c_fx, SIG_SHIFT'(0)})) - DIFF_W'($signed(c_fs));
    assign c_fnew = c_fs + STATE_BITS'(r_acc >>> COEF_FRAC);
    assign c_coef_sat = (r_prod > $signed(MUL_P_W'(COEF_ONE))) ? COEF_ONE
                                                                : r_prod[COEF_W-1:0];

    // top digit is signed, lower digits are plain magnitudes
    assign c_chunk    = r_diff[r_ck*CHUNK_W +: CHUNK_W];
    assign c_chunk_op = (r_ck == CK_TOP) ? $signed({c_chunk[CHUNK_W-1], c_chunk})
                                         : $signed({1'b0, c_chunk});

    assign c_v      = r_acc >>> GAIN_FRAC;
    assign c_hi_lim = ACC_W'($signed({1'b0, c_half}));
    assign c_lo_lim = -c_hi_lim;
    always_comb begin
        if (c_v > c_hi_lim) begin
            c_clamp = c_hi_lim;
        end else if (c_v < c_lo_lim) begin
            c_clamp = c_lo_lim;
        end else begin
            c_clamp = c_v;
        end
    end

    // multiplier operands follow the sequencer step
    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        case (r_state)
            S_COEF: begin
                c_mul_a = $signed(MUL_A_W'(c_rate));
                c_mul_b = $signed(MUL_B_W'(r_sample_period));
            end
            S_FMUL: begin
                c_mul_a = c_chunk_op;
                c_mul_b = $signed(MUL_B_W'(c_fcoef));
            end
            S_DGAIN: begin
                c_mul_a = r_damp_gain;
                c_mul_b = MUL_B_W'(c_hp);
            end
            S_OUTM: begin
                case (r_term)
                    T_FF: begin
                        c_mul_a = r_ff_gain;
                        c_mul_b = MUL_B_W'(c_vac);
                    end
                    T_KP: begin
                        c_mul_a = r_kp_gain;
                        c_mul_b = MUL_B_W'(r_err);
                    end
                    default: begin
                        c_mul_a = r_ks_gain;
                        c_mul_b = MUL_B_W'(c_lp);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    tpcc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (c_mul_a),
        .i_b   (c_mul_b),
        .o_p   (r_prod)
    );

    assign c_load = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_ph     = r_ph;
        n_ck     = r_ck;
        n_fsel   = r_fsel;
        n_term   = r_term;
        n_ovalid = r_ovalid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_COEF;
                    n_fsel  = F_OFF;
                    n_wait  = 1'b0;
                end
            end
            S_COEF: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    case (r_fsel)
                        F_OFF:   n_fsel = F_DAMP;
                        F_DAMP:  n_fsel = F_SLOW;
                        default: begin
                            n_ph    = '0;
                            n_fsel  = c_en ? F_DAMP : F_OFF;
                            n_state = S_FSET;
                        end
                    endcase
                end
            end
            S_FSET: begin
                n_ck    = CK_TOP;
                n_wait  = 1'b0;
                n_state = S_FMUL;
            end
            S_FMUL: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    if (r_ck == '0) begin
                        n_state = S_FUPD;
                    end else begin
                        n_ck = r_ck - 1'b1;
                    end
                end
            end
            S_FUPD: begin
                case (r_fsel)
                    F_OFF: begin
                        n_fsel  = F_DAMP;
                        n_state = S_FSET;
                    end
                    F_DAMP: begin
                        n_wait  = 1'b0;
                        n_state = S_DGAIN;
                    end
                    default: begin
                        n_wait  = 1'b0;
                        n_term  = T_FF;
                        n_state = S_OUTM;
                    end
                endcase
            end
            S_DGAIN: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait  = 1'b0;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_fsel  = F_SLOW;
                n_state = S_FSET;
            end
            S_OUTM: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    case (r_term)
                        T_FF:    n_term = T_KP;
                        T_KP:    n_term = T_KS;
                        default: n_state = S_CLAMP;
                    endcase
                end
            end
            S_CLAMP: begin
                if (r_ph == PH_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_ph    = r_ph + 1'b1;
                    n_fsel  = c_en ? F_DAMP : F_OFF;
                    n_state = S_FSET;
                end
            end
            S_DONE: begin
                // hold the finished result until the output register frees up
                if (c_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ph     <= '0;
            r_ck     <= '0;
            r_fsel   <= F_OFF;
            r_term   <= T_FF;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ph     <= n_ph;
            r_ck     <= n_ck;
            r_fsel   <= n_fsel;
            r_term   <= n_term;
            r_ovalid <= n_ovalid;
        end
    end

    // configuration registers and filter states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_rate   <= '0;
            r_damp_rate     <= '0;
            r_slow_rate     <= '0;
            r_sample_period <= '0;
            r_damp_gain     <= '0;
            r_ff_gain       <= '0;
            r_kp_gain       <= '0;
            r_ks_gain       <= '0;
            for (int p = 0; p < PHASE_COUNT; p++) begin
                r_offset[p] <= '0;
                r_damper[p] <= '0;
                r_errlp[p]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_OFFSET_RATE:       r_offset_rate   <= i_cfg_wdata[RATE_W-1:0];
                    CFG_DAMP_RATE:         r_damp_rate     <= i_cfg_wdata[RATE_W-1:0];
                    CFG_DAMP_GAIN:         r_damp_gain     <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                    CFG_SLOW_RATE:         r_slow_rate     <= i_cfg_wdata[RATE_W-1:0];
                    CFG_FEEDFORWARD_GAIN:  r_ff_gain       <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                    CFG_PROPORTIONAL_GAIN: r_kp_gain       <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                    CFG_SLOW_GAIN:         r_ks_gain       <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                    CFG_SAMPLE_PERIOD:     r_sample_period <= i_cfg_wdata[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_FUPD) begin
                case (r_fsel)
                    F_OFF:   r_offset[r_ph] <= c_fnew;
                    F_DAMP:  r_damper[r_ph] <= c_fnew;
                    default: r_errlp[r_ph]  <= c_fnew;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
        case (r_state)
            S_COEF: begin
                if (r_wait) begin
                    r_coef[r_fsel] <= c_coef_sat;
                end
            end
            S_FSET: begin
                r_diff <= DPAD_W'(c_diff);
            end
            S_FMUL: begin
                // fold digits in from the top: acc = acc * 2^CHUNK_W + digit * coef
                if (r_wait) begin
                    r_acc <= (r_ck == CK_TOP) ? ACC_W'(r_prod)
                                              : (r_acc <<< CHUNK_W) + ACC_W'(r_prod);
                end
            end
            S_DGAIN: begin
                if (r_wait) begin
                    r_ivd <= sat_sig(r_prod >>> GAIN_FRAC);
                end
            end
            S_ERR: begin
                r_err <= c_err_new;
            end
            S_OUTM: begin
                if (r_wait) begin
                    r_acc <= (r_term == T_FF) ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
                end
            end
            S_CLAMP: begin
                r_bridge[r_ph*OUT_W +: OUT_W] <= c_clamp[OUT_W-1:0];
            end
            default: begin
            end
        endcase
        if (c_load) begin
            r_obus <= r_bridge;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OBUS_W'(r_obus);

endmodule

/* hw/rtl/tpcc_mul.sv */
// Shared signed multiplier with a registered product
module tpcc_mul import tpcc_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/tpcc_checker.sv */
// Port-level checks of the current controller, bound to the top level
`include "three_phase_current_controller_top_defines.svh"

module tpcc_checker import tpcc_pkg::*; #(
    parameter int PHASE_COUNT = PHASE_COUNT_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    // bridge[phases], zero padded to whole bytes
    input logic [((OUT_W*PHASE_COUNT+7)/8)*8-1:0] m_axis_tdata
);

    localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(1) << (OUT_W - 1);

    `TPCC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `TPCC_ASSERT_NXT(a_busy_after_req, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready, "request taken while a tick is in progress")

    `TPCC_ASSERT_IMP(a_result_ends_tick, $rose(m_axis_tvalid),
                     s_axis_tready && ($past(s_axis_tready) == 1'b0),
                     "result appeared without a finished tick")

    // the clamp is symmetric, so the most negative code never shows up
    for (genvar g = 0; g < PHASE_COUNT; g++) begin : g_phase
        `TPCC_ASSERT_IMP(a_clamp_sym, m_axis_tvalid,
                         m_axis_tdata[g*OUT_W +: OUT_W] != OUT_MIN,
                         "bridge command outside the symmetric clamp")
    end

endmodule

bind three_phase_current_controller_top tpcc_checker #(
    .PHASE_COUNT (PHASE_COUNT)
) u_tpcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb.sv */
// Testbench of the three-phase current controller: directed and random control ticks
module tb;
    import tpcc_pkg::*;

    localparam int PHASES     = 3;
    localparam int FRAC_SHIFT = 16;              // Q12.20 filter state down to Q12.4
    localparam longint UNITY  = 64'sd1 <<< COEF_FRAC;

    // laid out exactly as s_axis_tdata, enable in bit 0
    typedef struct packed {
        logic [PHASES-1:0][SIG_W-1:0] i_target;
        logic [PHASES-1:0][SIG_W-1:0] i_meas;
        logic [PHASES-1:0][SIG_W-1:0] v_ac;
        logic [BUS_W-1:0]             bus;
        logic                         en;
    } tick_t;

    // laid out exactly as m_axis_tdata
    typedef struct packed {
        logic [2:0]                   pad;
        logic [PHASES-1:0][OUT_W-1:0] bridge;
    } bridge_t;

    typedef struct {
        logic [RATE_W-1:0]        offset_rate;
        logic [RATE_W-1:0]        damp_rate;
        logic [RATE_W-1:0]        slow_rate;
        logic [RATE_W-1:0]        period;
        logic signed [GAIN_W-1:0] damp_gain;
        logic signed [GAIN_W-1:0] ff_gain;
        logic signed [GAIN_W-1:0] p_gain;
        logic signed [GAIN_W-1:0] slow_gain;
    } ctrl_cfg_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [$bits(tick_t)-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [$bits(bridge_t)-1:0] m_axis_tdata;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_addr;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata;

    ctrl_cfg_t ctl_cfg;
    longint    offset_st [PHASES];
    longint    damper_st [PHASES];
    longint    err_lp_st [PHASES];
    bridge_t   bridge_q [$];
    int        mismatches;
    int        rx_hold;          // long receiver hold-off asked by a test, in cycles
    bit        quiet;            // no idle cycles on either side
    int        bias [PHASES];    // sensor offset built into measured currents

    three_phase_current_controller_top #(
        .PHASE_COUNT (PHASES),
        .STATE_BITS  (32)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint sat_sig(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint corner_coef(logic [RATE_W-1:0] rate);
        longint c;
        c = longint'(rate) * longint'(ctl_cfg.period);
        return (c > UNITY) ? UNITY : c;
    endfunction

    // move a first-order filter one tick toward x
    function automatic longint lowpass(longint st, longint x, longint c);
        longint diff;
        diff = x * (64'sd1 <<< FRAC_SHIFT) - st;
        return st + ((diff * c) >>> COEF_FRAC);
    endfunction

    function automatic bridge_t control_tick(tick_t t);
        bridge_t r;
        longint  half, c_off, c_damp, c_slow;
        longint  vac, im, it, ic, hp, ivd, err, acc, v;
        r      = '0;
        half   = longint'(t.bus >> 1);
        c_off  = corner_coef(ctl_cfg.offset_rate);
        c_damp = corner_coef(ctl_cfg.damp_rate);
        c_slow = corner_coef(ctl_cfg.slow_rate);
        for (int p = 0; p < PHASES; p++) begin
            vac = $signed(t.v_ac[p]);
            im  = $signed(t.i_meas[p]);
            it  = $signed(t.i_target[p]);
            // offset tracks only while the converter is off
            if (!t.en)
                offset_st[p] = lowpass(offset_st[p], im, c_off);
            ic = sat_sig(im - (offset_st[p] >>> FRAC_SHIFT));
            damper_st[p] = lowpass(damper_st[p], vac, c_damp);
            hp  = sat_sig(vac - (damper_st[p] >>> FRAC_SHIFT));
            ivd = sat_sig((hp * longint'(ctl_cfg.damp_gain)) >>> GAIN_FRAC);
            err = sat_sig(sat_sig(it - ivd) - ic);
            err_lp_st[p] = lowpass(err_lp_st[p], err, c_slow);
            acc = longint'(ctl_cfg.ff_gain) * vac + longint'(ctl_cfg.p_gain) * err
                + longint'(ctl_cfg.slow_gain) * (err_lp_st[p] >>> FRAC_SHIFT);
            v = acc >>> GAIN_FRAC;
            if (v > half) v = half;
            if (v < -half) v = -half;
            r.bridge[p] = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic tick_t flat_tick(bit en, int bus, int v, int im, int it);
        tick_t t;
        t.en  = en;
        t.bus = BUS_W'(bus);
        for (int p = 0; p < PHASES; p++) begin
            t.v_ac[p]     = SIG_W'(v);
            t.i_meas[p]   = SIG_W'(im);
            t.i_target[p] = SIG_W'(it);
        end
        return t;
    endfunction

    // mostly plausible operating points, now and then anything the fields allow
    function automatic tick_t random_tick(bit en);
        tick_t t;
        bit    wild;
        wild  = ($urandom_range(0, 4) == 0);
        t.en  = en;
        t.bus = wild ? BUS_W'($urandom) : BUS_W'($urandom_range(2000, 32767));
        for (int p = 0; p < PHASES; p++) begin
            if (wild) begin
                t.v_ac[p]     = SIG_W'($urandom);
                t.i_meas[p]   = SIG_W'($urandom);
                t.i_target[p] = SIG_W'($urandom);
            end else begin
                t.v_ac[p]     = SIG_W'(int'($urandom_range(0, 8191)) - 4096);
                t.i_target[p] = SIG_W'(int'($urandom_range(0, 2047)) - 1024);
                t.i_meas[p]   = SIG_W'(int'($signed(t.i_target[p])) + bias[p]
                                       + int'($urandom_range(0, 63)) - 32);
            end
        end
        return t;
    endfunction

    function automatic ctrl_cfg_t nominal_config();
        ctrl_cfg_t c;
        c.offset_rate = 1000;
        c.damp_rate   = 500;
        c.slow_rate   = 2000;
        c.period      = 1677;     // about 100 us
        c.damp_gain   = 512;
        c.ff_gain     = 1024;
        c.p_gain      = 2048;
        c.slow_gain   = 512;
        return c;
    endfunction

    function automatic ctrl_cfg_t random_config(bit wild);
        ctrl_cfg_t c;
        if (wild) begin
            c.offset_rate = RATE_W'($urandom);
            c.damp_rate   = RATE_W'($urandom);
            c.slow_rate   = RATE_W'($urandom);
            c.period      = RATE_W'($urandom);
            c.damp_gain   = GAIN_W'($urandom);
            c.ff_gain     = GAIN_W'($urandom);
            c.p_gain      = GAIN_W'($urandom);
            c.slow_gain   = GAIN_W'($urandom);
        end else begin
            c.offset_rate = RATE_W'($urandom_range(0, 3000));
            c.damp_rate   = RATE_W'($urandom_range(0, 3000));
            c.slow_rate   = RATE_W'($urandom_range(0, 3000));
            c.period      = RATE_W'($urandom_range(200, 3000));
            c.damp_gain   = GAIN_W'(int'($urandom_range(0, 8191)) - 4096);
            c.ff_gain     = GAIN_W'(int'($urandom_range(0, 8191)) - 4096);
            c.p_gain      = GAIN_W'(int'($urandom_range(0, 8191)) - 4096);
            c.slow_gain   = GAIN_W'(int'($urandom_range(0, 8191)) - 4096);
        end
        return c;
    endfunction

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_OFFSET_RATE:       ctl_cfg.offset_rate = val[RATE_W-1:0];
            CFG_DAMP_RATE:         ctl_cfg.damp_rate   = val[RATE_W-1:0];
            CFG_DAMP_GAIN:         ctl_cfg.damp_gain   = val;
            CFG_SLOW_RATE:         ctl_cfg.slow_rate   = val[RATE_W-1:0];
            CFG_FEEDFORWARD_GAIN:  ctl_cfg.ff_gain     = val;
            CFG_PROPORTIONAL_GAIN: ctl_cfg.p_gain      = val;
            CFG_SLOW_GAIN:         ctl_cfg.slow_gain   = val;
            CFG_SAMPLE_PERIOD:     ctl_cfg.period      = val[RATE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // write every register back to back; call only while the block is idle
    task automatic apply_config(ctrl_cfg_t c);
        put_reg(CFG_OFFSET_RATE,       CFG_DATA_W'(c.offset_rate));
        put_reg(CFG_DAMP_RATE,         CFG_DATA_W'(c.damp_rate));
        put_reg(CFG_DAMP_GAIN,         c.damp_gain);
        put_reg(CFG_SLOW_RATE,         CFG_DATA_W'(c.slow_rate));
        put_reg(CFG_FEEDFORWARD_GAIN,  c.ff_gain);
        put_reg(CFG_PROPORTIONAL_GAIN, c.p_gain);
        put_reg(CFG_SLOW_GAIN,         c.slow_gain);
        put_reg(CFG_SAMPLE_PERIOD,     CFG_DATA_W'(c.period));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick(tick_t t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        bridge_q.push_back(control_tick(t));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (bridge_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // registers at reset: every gain is zero, so every command is zero
    task automatic test_reset_state();
        send_tick(flat_tick(1, 32767, 32767, 32767, 32767));
        send_tick(flat_tick(0, 0, -32768, -32768, -32768));
        send_tick(flat_tick(0, 12345, 4000, -300, 700));
        wait_idle();
    endtask

    task automatic test_operating_point();
        tick_t t;
        apply_config(nominal_config());
        send_tick(flat_tick(0, 8000, 1000, 300, 0));
        send_tick(flat_tick(0, 8000, 1000, 300, 0));
        send_tick(flat_tick(1, 8000, 1000, 500, 400));
        // zero bus and odd bus clamp bounds
        send_tick(flat_tick(1, 0, 5000, -2000, 3000));
        send_tick(flat_tick(1, 1, 5000, -2000, 3000));
        send_tick(flat_tick(1, 3, -5000, 2000, -3000));
        send_tick(flat_tick(1, 32767, 32767, -32768, 32767));
        send_tick(flat_tick(1, 32767, -32768, 32767, -32768));
        t = flat_tick(0, 20001, 0, 0, 0);
        t.v_ac     = {16'h8000, 16'h0001, 16'h7fff};
        t.i_meas   = {16'h7fff, 16'hffff, 16'h8000};
        t.i_target = {16'h0000, 16'h8000, 16'h7fff};
        send_tick(t);
        wait_idle();
    endtask

    task automatic test_filter_extremes();
        ctrl_cfg_t c;
        // coefficient saturates at one: each filter jumps to its input
        c.offset_rate = 65535;
        c.damp_rate   = 65535;
        c.slow_rate   = 65535;
        c.period      = 65535;
        c.damp_gain   = -131072;
        c.ff_gain     = 131071;
        c.p_gain      = -131072;
        c.slow_gain   = 131071;
        apply_config(c);
        send_tick(flat_tick(0, 32767, 20000, -15000, 10000));
        send_tick(flat_tick(1, 32767, -20000, 15000, -10000));
        send_tick(flat_tick(0, 32766, 32767, 32767, -32768));
        wait_idle();
        // zero rates freeze the filters, gains at the opposite ends
        c.offset_rate = 0;
        c.damp_rate   = 0;
        c.slow_rate   = 0;
        c.damp_gain   = 131071;
        c.ff_gain     = -131072;
        c.p_gain      = 131071;
        c.slow_gain   = -131072;
        apply_config(c);
        send_tick(flat_tick(0, 32767, 12000, -8000, 6000));
        send_tick(flat_tick(1, 9999, -12000, 8000, -6000));
        send_tick(flat_tick(0, 32767, -32768, -32768, 32767));
        wait_idle();
        // exactly one, just above one, and far above
        c.offset_rate = 4096;
        c.damp_rate   = 4097;
        c.slow_rate   = 65535;
        c.period      = 4096;
        c.damp_gain   = 300;
        c.ff_gain     = 900;
        c.p_gain      = 1500;
        c.slow_gain   = 700;
        apply_config(c);
        send_tick(flat_tick(0, 16000, 3000, 200, 500));
        send_tick(flat_tick(1, 16000, -3000, -200, -500));
        wait_idle();
    endtask

    // hold the receiver off so the block fills up and stalls its input
    task automatic test_backpressure();
        apply_config(nominal_config());
        for (int p = 0; p < PHASES; p++)
            bias[p] = 0;
        quiet   = 1'b1;
        rx_hold = 400;
        repeat (8) send_tick(random_tick(1'b1));
        quiet   = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_runs();
        bit en;
        for (int run = 0; run < 9; run++) begin
            apply_config(random_config(run % 3 == 2));
            for (int p = 0; p < PHASES; p++)
                bias[p] = int'($urandom_range(0, 1023)) - 512;
            quiet = ($urandom_range(0, 3) == 0);
            en    = 1'b0;
            // start disabled so the offsets settle, then run with rare toggles
            for (int i = 0; i < 50; i++) begin
                if (i == 12)
                    en = 1'b1;
                else if ($urandom_range(0, 19) == 0)
                    en = !en;
                send_tick(random_tick(en));
            end
            quiet = 1'b0;
            wait_idle();
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 5);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bridge_t got;
            bridge_t want;
            got = m_axis_tdata;
            if (bridge_q.size() == 0) begin
                flag_mismatch($sformatf("result with none expected: %0d %0d %0d",
                              $signed(got.bridge[0]), $signed(got.bridge[1]),
                              $signed(got.bridge[2])));
            end else begin
                want = bridge_q.pop_front();
                for (int p = 0; p < PHASES; p++)
                    if (got.bridge[p] !== want.bridge[p])
                        flag_mismatch($sformatf("bridge phase %0d: expected %0d, got %0d",
                                      p, $signed(want.bridge[p]), $signed(got.bridge[p])));
            end
        end
    end

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        mismatches    = 0;
        rx_hold       = 0;
        quiet         = 1'b0;
        ctl_cfg       = '{default: '0};
        foreach (offset_st[p]) begin
            offset_st[p] = 0;
            damper_st[p] = 0;
            err_lp_st[p] = 0;
            bias[p]      = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_operating_point();
        test_filter_extremes();
        test_backpressure();
        test_random_runs();
        wait_idle();
        repeat (120) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* three_phase_current_controller_top.f */
+incdir+hw/rtl
hw/rtl/tpcc_pkg.sv
hw/rtl/tpcc_mul.sv
hw/rtl/three_phase_current_controller_top.sv
hw/rtl/tpcc_checker.sv
bench/tb.sv
